[sv/egcd_pkg.sv]
package egcd_pkg;

   localparam int LIMB_COUNT = 4;
   localparam int LIMB_W     = 64;
   localparam int LIMB_IDX_W = 2;
   localparam int OP_W       = LIMB_COUNT * LIMB_W;
   localparam int COEF_W     = (LIMB_COUNT + 1) * LIMB_W;
   localparam int BIT_CNT_W  = $clog2(OP_W);

   localparam logic       ACT_WRITE_A = 1'b0;
   localparam logic       ACT_WRITE_B = 1'b1;
   localparam logic [1:0] RES_GCD     = 2'd0;
   localparam logic [1:0] RES_U       = 2'd1;
   localparam logic [1:0] RES_V       = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHECK,
      ST_DIV,
      ST_UPD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  action;
      logic [LIMB_IDX_W-1:0] limb_index;
      logic [LIMB_W-1:0]     limb_value;
      logic                  start_req;
   } req_type;

   typedef struct packed {
      logic [1:0]            which_result;
      logic [LIMB_IDX_W-1:0] out_limb_index;
      logic [LIMB_W-1:0]     out_limb_value;
      logic                  negative;
      logic                  last_result;
   } rsp_type;

endpackage

[sv/extended_gcd_bezout.sv]
// extended euclid on 256-bit operands, gcd and bezout coefficients as 64-bit limbs
// sequence: each euclid step is a check, one quotient bit per cycle in the divide, then an update;
// after the last step come 12 result beats, one per cycle when rsp_stall is low
// throughput: one run at a time; req_stall stays high from a start beat to the last beat
// reset: synchronous, clears the sequencer and the result valid; operand stores are not cleared
module extended_gcd_bezout
   import egcd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // operand stores, one limb written per beat
   logic [LIMB_W-1:0] a_store [LIMB_COUNT];
   logic [LIMB_W-1:0] b_store [LIMB_COUNT];

   state_type state_ff, state_in;

   // remainders, running partial remainder of the divide
   logic [OP_W-1:0] prev_ff, curr_ff, rem_ff;
   // coefficient pairs, two's complement mod 2^320
   logic [COEF_W-1:0] u_old_ff, u_new_ff, v_old_ff, v_new_ff;
   // q*new accumulated msb first during the divide
   logic [COEF_W-1:0] acc_u_ff, acc_v_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;

   // result sequencing
   logic [1:0]            which_ff;
   logic [LIMB_IDX_W-1:0] limb_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic req_accept, rsp_load, div_done, emit_done, curr_zero;
   logic [OP_W:0]   shifted, diff;
   logic            ge;
   logic [COEF_W-1:0] coef_sel, coef_mag, word_src;
   logic [OP_W-1:0] a_vec, b_vec;

   always_comb begin
      for (int i = 0; i < LIMB_COUNT; i++) begin
         a_vec[i*LIMB_W +: LIMB_W] = a_store[i];
         b_vec[i*LIMB_W +: LIMB_W] = b_store[i];
      end
   end

   // one restoring divide step: shift in the next dividend bit, trial subtract
   assign shifted   = {rem_ff, prev_ff[OP_W-1]};
   assign diff      = shifted - {1'b0, curr_ff};
   assign ge        = shifted >= {1'b0, curr_ff};
   assign div_done  = bit_cnt_ff == BIT_CNT_W'(OP_W - 1);
   assign curr_zero = curr_ff == '0;
   assign emit_done = (which_ff == RES_V) && (limb_ff == LIMB_IDX_W'(LIMB_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept && req_data.start_req) state_in = ST_INIT;
         ST_INIT:  state_in = ST_CHECK;
         ST_CHECK: state_in = curr_zero ? ST_EMIT : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_UPD;
         ST_UPD:   state_in = ST_CHECK;
         ST_EMIT:  if (rsp_load && emit_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // handshake control
   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      req_accept = req_valid && !req_stall;
      rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   end

   // magnitude of the selected coefficient, or the gcd, as the source of the result word
   always_comb begin
      coef_sel = (which_ff == RES_U) ? u_old_ff : v_old_ff;
      coef_mag = coef_sel[COEF_W-1] ? (~coef_sel + COEF_W'(1)) : coef_sel;
      word_src = (which_ff == RES_GCD) ? {{(COEF_W-OP_W){1'b0}}, prev_ff} : coef_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         which_ff     <= RES_GCD;
         limb_ff      <= '0;
         bit_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (limb_ff == LIMB_IDX_W'(LIMB_COUNT - 1)) begin
               limb_ff  <= '0;
               which_ff <= emit_done ? RES_GCD : which_ff + 2'd1;
            end else begin
               limb_ff <= limb_ff + LIMB_IDX_W'(1);
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DIV) bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
         else                    bit_cnt_ff <= '0;
      end
   end

   // operand stores
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (req_data.action == ACT_WRITE_A) a_store[req_data.limb_index] <= req_data.limb_value;
         else                                b_store[req_data.limb_index] <= req_data.limb_value;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_INIT: begin
            prev_ff  <= a_vec;
            curr_ff  <= b_vec;
            u_old_ff <= COEF_W'(1);
            u_new_ff <= '0;
            v_old_ff <= '0;
            v_new_ff <= COEF_W'(1);
         end
         ST_CHECK: begin
            rem_ff   <= '0;
            acc_u_ff <= '0;
            acc_v_ff <= '0;
         end
         ST_DIV: begin
            rem_ff   <= ge ? diff[OP_W-1:0] : shifted[OP_W-1:0];
            prev_ff  <= {prev_ff[OP_W-2:0], 1'b0};
            acc_u_ff <= {acc_u_ff[COEF_W-2:0], 1'b0} + (ge ? u_new_ff : '0);
            acc_v_ff <= {acc_v_ff[COEF_W-2:0], 1'b0} + (ge ? v_new_ff : '0);
         end
         ST_UPD: begin
            prev_ff  <= curr_ff;
            curr_ff  <= rem_ff;
            u_old_ff <= u_new_ff;
            u_new_ff <= u_old_ff - acc_u_ff;
            v_old_ff <= v_new_ff;
            v_new_ff <= v_old_ff - acc_v_ff;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_ff.which_result   <= which_ff;
         rsp_ff.out_limb_index <= limb_ff;
         rsp_ff.out_limb_value <= word_src[limb_ff*LIMB_W +: LIMB_W];
         rsp_ff.negative       <= (which_ff != RES_GCD) && coef_sel[COEF_W-1];
         rsp_ff.last_result    <= emit_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
